// ===== rtl/jse_pkg.sv =====
// shared types, constants and helper functions for the json string escaper
`timescale 1ns / 1ps

package jse_pkg;

  localparam int MAX_BEATS   = 7;
  localparam int BODY_BEATS  = 6;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [15:0] DEF_BUF_LEN = 16'd256;
  localparam logic [16:0] ESC_ROOM    = 17'd7;
  localparam logic [7:0]  CTRL_LIMIT  = 8'h20;
  localparam logic [3:0]  NIBBLE_MASK = 4'hF;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] HEX_ALPHA = 8'h57;

  // one queued command: all beats one input byte causes
  typedef struct packed {
    logic [MAX_BEATS-1:0][7:0] bytes;
    logic [2:0]                cnt;
    logic                      term;
    logic [15:0]               pos;
    logic [15:0]               tpos;
  } cmd_t;

  // second character of a two-byte escape, zero if none
  function automatic logic [7:0] esc_char(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      CH_QUOTE:  r = CH_QUOTE;
      CH_BSLASH: r = CH_BSLASH;
      CH_BS:     r = CH_LC_B;
      CH_FF:     r = CH_LC_F;
      CH_LF:     r = CH_LC_N;
      CH_CR:     r = CH_LC_R;
      CH_TAB:    r = CH_LC_T;
      default:   r = CH_NUL;
    endcase
    return r;
  endfunction

  // lowercase hex digit
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] r;
    r = (n < 4'd10) ? (CH_ZERO + {4'd0, n}) : (HEX_ALPHA + {4'd0, n});
    return r;
  endfunction

endpackage

// ===== rtl/jse_if.sv =====
// valid/ready channel interfaces for input bytes and output beats
`timescale 1ns / 1ps

interface jse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

interface jse_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [15:0] out_pos;
  logic        last;
  logic        string_done;

  modport source (output valid, output out_byte, output out_pos, output last,
                  output string_done, input ready);
  modport sink   (input valid, input out_byte, input out_pos, input last,
                  input string_done, output ready);
endinterface

// ===== rtl/jse_front.sv =====
// front end: accepts source bytes, tracks write position, builds beat commands
`timescale 1ns / 1ps

module jse_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [15:0]   buf_len,
  jse_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          q_push,
  output jse_pkg::cmd_t q_cmd
);
  import jse_pkg::*;

  logic [15:0] wp_r, wp_nxt;
  logic        open_r, open_nxt;

  logic        accept, len_nz, is_end, need_q, room, close_ok, term;
  logic [7:0]  c, esc;
  logic [15:0] wp0, wpb, wpc, tpos;
  logic [BODY_BEATS-1:0][7:0] body;
  logic [2:0]  bc, cnt;
  logic [MAX_BEATS-1:0][7:0] bytes;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.char_byte;
  assign len_nz      = (buf_len != 16'd0);
  assign is_end      = (c == CH_NUL);
  assign need_q      = !open_r && len_nz;
  assign wp0         = open_r ? wp_r : 16'd0;
  assign wpb         = wp0 + {15'd0, need_q};
  assign room        = len_nz && (({1'b0, wpb} + ESC_ROOM) < {1'b0, buf_len});
  assign close_ok    = len_nz && (({1'b0, wpb} + 17'd1) < {1'b0, buf_len});
  assign esc         = esc_char(c);
  assign term        = is_end && len_nz;
  assign wpc         = wpb + {15'd0, close_ok};
  // terminator position clamps to the last buffer slot
  assign tpos        = (wpc < buf_len) ? wpc : (buf_len - 16'd1);

  always_comb begin
    body = '0;
    bc   = 3'd0;
    if (is_end) begin
      if (close_ok) begin
        body[0] = CH_QUOTE;
        bc      = 3'd1;
      end
    end else if (room) begin
      if (esc != CH_NUL) begin
        body[0] = CH_BSLASH;
        body[1] = esc;
        bc      = 3'd2;
      end else if (c < CTRL_LIMIT) begin
        body[0] = CH_BSLASH;
        body[1] = CH_LC_U;
        body[2] = CH_ZERO;
        body[3] = CH_ZERO;
        body[4] = hex_digit(c[7:4] & NIBBLE_MASK);
        body[5] = hex_digit(c[3:0] & NIBBLE_MASK);
        bc      = 3'd6;
      end else begin
        body[0] = c;
        bc      = 3'd1;
      end
    end
  end

  // opening quote shifts the body up one slot
  always_comb begin
    bytes = '0;
    if (need_q) begin
      bytes[0] = CH_QUOTE;
      for (int k = 1; k < MAX_BEATS; k++) begin
        bytes[k] = body[k-1];
      end
    end else begin
      for (int k = 0; k < BODY_BEATS; k++) begin
        bytes[k] = body[k];
      end
    end
  end

  assign cnt = {2'd0, need_q} + bc + {2'd0, term};

  assign q_push     = accept && len_nz && (cnt != 3'd0);
  assign q_cmd.bytes = bytes;
  assign q_cmd.cnt   = cnt;
  assign q_cmd.term  = term;
  assign q_cmd.pos   = wp0;
  assign q_cmd.tpos  = tpos;

  always_comb begin
    wp_nxt   = wp_r;
    open_nxt = open_r;
    if (accept) begin
      if (is_end) begin
        wp_nxt   = 16'd0;
        open_nxt = 1'b0;
      end else if (len_nz) begin
        wp_nxt   = wpb + {13'd0, bc};
        open_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 16'd0;
      open_r <= 1'b0;
    end else begin
      wp_r   <= wp_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

// ===== rtl/jse_queue.sv =====
// command queue between front and back ends
`timescale 1ns / 1ps

module jse_queue #(
  parameter int DEPTH = jse_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jse_pkg::cmd_t push_cmd,
  input  logic          pop,
  output jse_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import jse_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/jse_back.sv =====
// back end: walks each queued command and drives one output beat per cycle while out_ch is ready
`timescale 1ns / 1ps

module jse_back (
  input  logic          clk,
  input  logic          rst_n,
  input  jse_pkg::cmd_t head,
  input  logic          q_empty,
  output logic          q_pop,
  jse_out_if.source     out_ch
);
  import jse_pkg::*;

  logic        ov_r, ov_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [7:0]  ob_r;
  logic [15:0] op_r;
  logic        ol_r, od_r;
  logic        load, at_last;

  assign load    = !q_empty && (!ov_r || out_ch.ready);
  assign at_last = (idx_r == (head.cnt - 3'd1));
  assign q_pop   = load && at_last;

  always_comb begin
    ov_nxt  = ov_r;
    idx_nxt = idx_r;
    if (load) begin
      ov_nxt  = 1'b1;
      idx_nxt = at_last ? 3'd0 : idx_r + 3'd1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= 3'd0;
    end else begin
      ov_r  <= ov_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob_r <= head.bytes[idx_r];
      // terminator beat goes to the clamped slot
      op_r <= (head.term && at_last) ? head.tpos : head.pos + {13'd0, idx_r};
      ol_r <= at_last;
      od_r <= head.term && at_last;
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.out_byte    = ob_r;
  assign out_ch.out_pos     = op_r;
  assign out_ch.last        = ol_r;
  assign out_ch.string_done = od_r;

endmodule

// ===== rtl/json_string_escaper.sv =====
// top level of the json string escaper
// the first output beat of an accepted byte passes the command queue, then the back end register
// throughput: one output beat per cycle while out_ch is ready, set by the back end
// beats per byte: 1 plain, 2 or 6 escaped, 0 if dropped, +1 opening the string, 1 to 3 at end
// input stalls only when the command queue between front and back is full
// reset (synchronous, active low) clears position, quote, queue, valid; length back to 256
`timescale 1ns / 1ps

module json_string_escaper #(
  parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  jse_in_if.sink      in_ch,
  jse_out_if.source   out_ch
);
  import jse_pkg::*;

  logic [15:0] buf_len_r, buf_len_nxt;
  logic        q_push, q_pop, q_full, q_empty;
  cmd_t        push_cmd, head;

  assign buf_len_nxt = cfg_we ? cfg_wdata : buf_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_len_r <= DEF_BUF_LEN;
    end else begin
      buf_len_r <= buf_len_nxt;
    end
  end

  jse_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .buf_len (buf_len_r),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (push_cmd)
  );

  jse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  jse_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full command queue");

  a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.char_byte == CH_NUL) && (buf_len_r != 16'd0))
      |-> q_push)
    else $error("string end with nonzero length gave no command");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.string_done) |-> (out_ch.last && (out_ch.out_byte == CH_NUL)))
    else $error("terminator beat not last or not zero");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty command queue");
`endif

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the json string escaper
`timescale 1ns / 1ps

module testbench;
  import jse_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 30;

  typedef struct packed {
    logic [7:0]  ch;
    logic [15:0] pos;
    logic        last;
    logic        done;
  } beat_t;

  // predicts the escaped output and holds the beats still to come
  class escape_scoreboard;
    logic [15:0] buf_len;
    logic [15:0] write_pos;
    bit          quote_opened;
    beat_t       waiting_beats[$];
    int          errors;

    function new();
      buf_len = DEF_BUF_LEN;
      write_pos = '0;
      quote_opened = 0;
      errors = 0;
    endfunction

    function void set_length(logic [15:0] v);
      buf_len = v;
    endfunction

    function void put_beat(ref beat_t row[$], input logic [7:0] ch);
      beat_t b;
      b.ch = ch;
      b.pos = write_pos;
      b.last = 1'b0;
      b.done = 1'b0;
      row.push_back(b);
      write_pos = write_pos + 16'd1;
    endfunction

    function void note_byte(logic [7:0] c);
      int unsigned len;
      beat_t       row[$];
      beat_t       term;
      logic [7:0]  esc;
      string       digits = "0123456789abcdef";
      len = buf_len;
      if (len == 0) begin
        if (c == CH_NUL) begin
          write_pos = '0;
          quote_opened = 0;
        end
        return;
      end
      if (!quote_opened) begin
        write_pos = '0;
        put_beat(row, CH_QUOTE);
        quote_opened = 1;
      end
      if (c != CH_NUL) begin
        // no room for the longest escape: byte dropped, position stays
        if (write_pos + 7 < len) begin
          case (c)
            CH_QUOTE:  esc = CH_QUOTE;
            CH_BSLASH: esc = CH_BSLASH;
            CH_BS:     esc = CH_LC_B;
            CH_FF:     esc = CH_LC_F;
            CH_LF:     esc = CH_LC_N;
            CH_CR:     esc = CH_LC_R;
            CH_TAB:    esc = CH_LC_T;
            default:   esc = CH_NUL;
          endcase
          if (esc != CH_NUL) begin
            put_beat(row, CH_BSLASH);
            put_beat(row, esc);
          end else if (c < CTRL_LIMIT) begin
            put_beat(row, CH_BSLASH);
            put_beat(row, CH_LC_U);
            put_beat(row, CH_ZERO);
            put_beat(row, CH_ZERO);
            put_beat(row, digits[c[7:4]]);
            put_beat(row, digits[c[3:0]]);
          end else begin
            put_beat(row, c);
          end
        end
      end else begin
        if (write_pos + 1 < len) put_beat(row, CH_QUOTE);
        term.ch = CH_NUL;
        term.pos = (write_pos < len) ? write_pos : 16'(len - 1);
        term.last = 1'b0;
        term.done = 1'b1;
        row.push_back(term);
        write_pos = '0;
        quote_opened = 0;
      end
      if (row.size() > 0) row[$].last = 1'b1;
      foreach (row[i]) waiting_beats.push_back(row[i]);
    endfunction

    function void check_beat(logic [7:0] ch, logic [15:0] pos, logic last, logic done);
      beat_t e;
      if (waiting_beats.size() == 0) begin
        $error("unexpected beat: out_byte %h out_pos %0d", ch, pos);
        errors++;
        return;
      end
      e = waiting_beats.pop_front();
      if (ch !== e.ch) begin
        $error("out_byte: expected %h, got %h", e.ch, ch);
        errors++;
      end
      if (pos !== e.pos) begin
        $error("out_pos: expected %0d, got %0d", e.pos, pos);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %b, got %b", e.last, last);
        errors++;
      end
      if (done !== e.done) begin
        $error("string_done: expected %b, got %b", e.done, done);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  jse_in_if  in_ch ();
  jse_out_if out_ch ();

  json_string_escaper i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  escape_scoreboard sb;
  int  cycles;
  int  rx_wait;
  bit  rx_busy;
  bit  tx_busy;
  int  items_sent;

  logic [7:0] esc_set [7] = '{CH_QUOTE, CH_BSLASH, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB};
  logic [15:0] len_plan [10] = '{16'd64, 16'd0, 16'd65535, 16'd9, 16'd12, 16'd1, 16'd2,
                                 16'd30, 16'd0, 16'd256};

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: check each beat, then maybe hold ready low for a while
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_beat(out_ch.out_byte, out_ch.out_pos, out_ch.last, out_ch.string_done);
      rx_wait = rx_busy ? $urandom_range(0, 11) : 0;
    end
  end

  always @(negedge clk) begin
    if (rx_wait > 0) begin
      out_ch.ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = tx_busy ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.char_byte <= c;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(c);
    items_sent++;
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.waiting_beats.size() != 0) @(posedge clk);
  endtask

  task automatic write_length(input logic [15:0] v);
    wait_results();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_length(v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 9))
      0, 1:    return esc_set[$urandom_range(0, 6)];
      2:       return 8'($urandom_range(1, 31));
      3:       return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  task automatic send_string(input bit noisy, input bit close, input bit pause_inside);
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    for (int i = 0; i < n; i++) begin
      send_byte(noisy ? 8'($urandom_range(0, 255)) : text_byte());
      // sender holds off until everything owed has come out
      if (pause_inside && i == n / 2) wait_results();
    end
    if (close) send_byte(CH_NUL);
  endtask

  initial begin
    int phase_start;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.char_byte = '0;
    out_ch.ready = 1'b0;
    cycles = 0;
    rx_wait = 0;
    rx_busy = 1;
    tx_busy = 1;
    items_sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every escape class and both values of every bit, default length
    send_byte(CH_QUOTE);
    send_byte(CH_BSLASH);
    send_byte(CH_BS);
    send_byte(CH_FF);
    send_byte(CH_LF);
    send_byte(CH_TAB);
    send_byte(CH_CR);
    send_byte(8'h01);
    send_byte(8'h1F);
    send_byte(8'h20);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(CH_NUL);
    // zero length swallows everything
    write_length(16'd0);
    send_byte(8'h61);
    send_byte(CH_NUL);
    // length one: terminator lands on the opening quote
    write_length(16'd1);
    send_byte(8'h78);
    send_byte(CH_NUL);
    // length two: empty string, no room for the closing quote
    write_length(16'd2);
    send_byte(CH_NUL);
    // room check just fails, then just passes
    write_length(16'd8);
    send_byte(8'h01);
    send_byte(8'h7A);
    send_byte(CH_NUL);
    write_length(16'd9);
    send_byte(8'h01);
    send_byte(CH_NUL);

    // random strings over a spread of lengths, some left open across a change
    foreach (len_plan[p]) begin
      write_length((p == 8) ? 16'($urandom_range(3, 40)) : len_plan[p]);
      tx_busy = ($urandom_range(0, 3) != 0);
      rx_busy = ($urandom_range(0, 3) != 0);
      phase_start = items_sent;
      while (items_sent - phase_start < 20)
        send_string($urandom_range(0, 4) == 0, 1'b1,
                    (p == 0 && items_sent == phase_start) || $urandom_range(0, 9) == 0);
      if ($urandom_range(0, 2) == 0) send_string(1'b0, 1'b0, 1'b0);
    end

    wait_results();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.waiting_beats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
